/* rtl/ihash_pkg.sv */
// Shared types and constants for the identifier name hash block.
package ihash_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned HASH_W = 64;
    localparam int unsigned CNT_W  = 6;

    typedef struct packed {
        logic load;
        logic div_step;
        logic update;
        logic emit;
    } ihash_cmd_t;

    typedef struct packed {
        logic pending;
        logic last_item;
        logic div_done;
        logic out_busy;
    } ihash_sts_t;

endpackage

/* rtl/ihash_if.sv */
// Valid/ready channel interfaces for name bytes and hash results.
interface ihash_byte_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [5:0] name_length;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output start_req, output name_length, output ch,
                    output last, input ready);
    modport sink (input valid, input start_req, input name_length, input ch,
                  input last, output ready);
endinterface

interface ihash_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        bad_name;

    modport source (output valid, output hash_value, output bad_name, input ready);
    modport sink (input valid, input hash_value, input bad_name, output ready);
endinterface

/* rtl/ihash_ctrl.sv */
// Sequencer for byte intake, serial division, lane update and result hand-off.
module ihash_ctrl
    import ihash_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ihash_sts_t sts,
    output ihash_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = sts.pending ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.last_item)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ihash_dp.sv */
// Hash state, bit-serial divider with quotient mod 5, lane update and result register.
module ihash_dp
    import ihash_pkg::*;
#(
    parameter int unsigned MAX_NAME = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ihash_cmd_t          cmd,
    output ihash_sts_t          sts,
    input  logic                start_req,
    input  logic [LEN_W-1:0]    name_length,
    input  logic [CHAR_W-1:0]   ch,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HASH_W-1:0]   hash_value,
    output logic                bad_name
);

    localparam logic [7:0]       MAX_LIM   = 8'(MAX_NAME);
    localparam logic [LEN_W-1:0] IDX_LIMIT = 6'd63;
    localparam logic [7:0]       CH_UP_LO  = 8'h41;
    localparam logic [7:0]       CH_UP_HI  = 8'h5A;
    localparam logic [7:0]       CH_LO_LO  = 8'h61;
    localparam logic [7:0]       CH_LO_HI  = 8'h7F;
    localparam logic [7:0]       CH_DIG_LO = 8'h30;
    localparam logic [7:0]       CH_DIG_HI = 8'h39;
    localparam logic [7:0]       CH_USCORE = 8'h5F;
    localparam logic [7:0]       CH_AT     = 8'h40;
    localparam logic [7:0]       CH_QMARK  = 8'h3F;
    localparam logic [7:0]       CASE_OFS  = 8'h20;

    function automatic logic [7:0] fold_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UP_LO && b <= CH_UP_HI)
        begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic legal_byte(input logic [7:0] b);
        logic ok;
        ok = (b >= CH_LO_LO && b <= CH_LO_HI) || (b >= CH_DIG_LO && b <= CH_DIG_HI)
            || b == CH_USCORE || b == CH_AT || b == CH_QMARK;
        return ok;
    endfunction

    logic [HASH_W-1:0] hash_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic              err_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic              last_reg;
    logic              pend_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [2:0]        qm_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic              out_bad_reg;
    logic              out_valid_reg;

    // intake
    logic [HASH_W-1:0] h_eff;
    logic [LEN_W-1:0]  idx_eff;
    logic              err_eff;
    logic              consume;
    logic              in_range;
    logic [CHAR_W-1:0] b_fold;

    always_comb
    begin
        h_eff    = start_req ? {{(HASH_W-LEN_W){1'b0}}, name_length} : hash_reg;
        idx_eff  = start_req ? '0 : idx_reg;
        err_eff  = start_req ? ({2'b00, name_length} > MAX_LIM) : err_reg;
        consume  = !start_req || (name_length != '0);
        in_range = ({2'b00, idx_eff} < MAX_LIM) && (idx_eff < IDX_LIMIT);
        b_fold   = fold_lower(ch);
    end

    // one restoring step per cycle, quotient tracked mod 5
    logic       div_bit;
    logic [6:0] rem_sh;
    logic [6:0] divisor;
    logic       q_ge;
    logic [LEN_W-1:0] rem_next;
    logic [3:0] qm_dbl;
    logic [2:0] qm_next;

    always_comb
    begin
        div_bit  = hash_reg[cnt_reg];
        rem_sh   = {rem_reg, div_bit};
        divisor  = {1'b0, idx_reg} + 7'd1;
        q_ge     = rem_sh >= divisor;
        rem_next = q_ge ? 6'(rem_sh - divisor) : rem_sh[5:0];
        qm_dbl   = {qm_reg, 1'b0} + {3'b000, q_ge};
        qm_next  = (qm_dbl >= 4'd5) ? 3'(qm_dbl - 4'd5) : qm_dbl[2:0];
    end

    // lane update
    logic [2:0]        lane;
    logic [CHAR_W-1:0] add_val;
    logic [CHAR_W-1:0] lane_new;

    always_comb
    begin
        lane     = idx_reg[2:0];
        add_val  = byte_reg + {2'b00, idx_reg} + (byte_reg >> qm_reg);
        lane_new = hash_reg[lane*8 +: 8] + add_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            idx_reg       <= '0;
            err_reg       <= 1'b0;
            last_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                hash_reg <= h_eff;
                idx_reg  <= idx_eff;
                err_reg  <= err_eff | (consume && (!in_range || !legal_byte(b_fold)));
                pend_reg <= consume && in_range;
                last_reg <= last;
            end
            else if (cmd.update)
            begin
                hash_reg[lane*8 +: 8] <= lane_new;
                idx_reg               <= idx_reg + 6'd1;
            end
            else if (cmd.emit)
            begin
                hash_reg <= '0;
                idx_reg  <= '0;
                err_reg  <= 1'b0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= b_fold;
            rem_reg  <= '0;
            qm_reg   <= '0;
            cnt_reg  <= CNT_W'(HASH_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            qm_reg  <= qm_next;
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (cmd.emit)
        begin
            out_hash_reg <= err_reg ? '0 : hash_reg;
            out_bad_reg  <= err_reg;
        end
    end

    assign sts.pending   = pend_reg;
    assign sts.last_item = last_reg;
    assign sts.div_done  = (cnt_reg == '0);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;
    assign bad_name   = out_bad_reg;

endmodule

/* rtl/identifier_name_hash_top.sv */
// Top level of the identifier name hash block.
// Usage:
//   byte_ch carries one name byte per transfer: start_req opens a name and
//   loads name_length as the starting hash, last closes it. hash_ch carries
//   one result (hash_value, bad_name) for each byte transfer with last set.
// Timing:
//   A hashed byte passes through the intake, decision, divide, lane update
//   and finish states before the next byte is taken; the divide state runs a
//   bit-serial divider (running hash over position+1, one quotient bit per
//   cycle). A byte that is skipped (empty start, or past the length limit)
//   goes from the decision state straight to the finish state. A result is
//   valid in the cycle after the finish state.
// Reset: hash, position, error flag and the result valid flag clear; the
//   block is ready for a byte right after reset.
// Stall: the result sits in an output register while the next bytes are
//   taken; a later result waits in the finish cycle until the slot frees.
module identifier_name_hash_top
    import ihash_pkg::*;
#(
    parameter int unsigned MAX_NAME = 63
)
(
    input logic        clk,
    input logic        rst_n,
    ihash_byte_if.sink byte_ch,
    ihash_hash_if.source hash_ch
);

    ihash_cmd_t cmd;
    ihash_sts_t sts;

    ihash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ihash_dp #(
        .MAX_NAME (MAX_NAME)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .start_req   (byte_ch.start_req),
        .name_length (byte_ch.name_length),
        .ch          (byte_ch.ch),
        .last        (byte_ch.last),
        .out_valid   (hash_ch.valid),
        .out_ready   (hash_ch.ready),
        .hash_value  (hash_ch.hash_value),
        .bad_name    (hash_ch.bad_name)
    );

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.update, cmd.emit}))
        else $error("more than one datapath command active");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!hash_ch.valid || hash_ch.ready))
        else $error("result written over a pending transfer");

    a_div_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_done) |=> cmd.update)
        else $error("lane update did not follow the last divide step");

    a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !byte_ch.ready)
        else $error("byte channel ready during division");
`endif

endmodule

/* bench/identifier_name_hash_top_test.sv */
// Self-checking testbench for the identifier name hash block.
module identifier_name_hash_top_test
    import ihash_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LIMIT  = 63;
    localparam int ITEM_TARGET = 800;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        logic              start_req;
        logic [LEN_W-1:0]  name_length;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              hold;
    } name_byte_t;

    typedef struct {
        logic [HASH_W-1:0] hash;
        logic              bad;
    } name_hash_t;

    logic clk;
    logic rst_n;

    ihash_byte_if byte_ch ();
    ihash_hash_if hash_ch ();

    identifier_name_hash_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .hash_ch (hash_ch)
    );

    name_byte_t byte_queue[$];
    name_hash_t hash_queue[$];
    name_byte_t cur_byte;

    logic [HASH_W-1:0] hash_acc;
    logic [CNT_W-1:0]  byte_pos;
    logic              name_bad;

    int errors;
    int total_bytes;
    int sent_bytes;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic bit legal_char(input logic [CHAR_W-1:0] b);
        return (b >= 8'h61 && b <= 8'h7F) || (b >= 8'h30 && b <= 8'h39) ||
               b == 8'h5F || b == 8'h40 || b == 8'h3F;
    endfunction

    function automatic void hash_char(input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] b;
        logic [HASH_W-1:0] quot;
        int                sh;
        int                sum;
        int                lane;
        b = (raw >= 8'h41 && raw <= 8'h5A) ? raw + 8'h20 : raw;
        if (int'(byte_pos) >= NAME_LIMIT)
        begin
            name_bad = 1'b1;
            return;
        end
        if (!legal_char(b))
            name_bad = 1'b1;
        quot = hash_acc / (64'(byte_pos) + 64'd1);
        sh   = int'(quot % 64'd5);
        sum  = int'(b) + int'(byte_pos) + int'(b >> sh);
        lane = int'(byte_pos[2:0]);
        hash_acc[lane*8 +: 8] = hash_acc[lane*8 +: 8] + sum[7:0];
        byte_pos = byte_pos + 1'b1;
    endfunction

    function automatic void predict_hash(input name_byte_t it);
        name_hash_t res;
        bit         take;
        take = 1'b1;
        if (it.start_req)
        begin
            hash_acc = 64'(it.name_length);
            byte_pos = '0;
            name_bad = int'(it.name_length) > NAME_LIMIT;
            if (it.name_length == 0)
                take = 1'b0;
        end
        if (take)
            hash_char(it.ch);
        if (it.last)
        begin
            res.hash = name_bad ? '0 : hash_acc;
            res.bad  = name_bad;
            hash_queue.push_back(res);
            hash_acc = '0;
            byte_pos = '0;
            name_bad = 1'b0;
        end
    endfunction

    function automatic void add_byte(input logic s, input logic [LEN_W-1:0] len,
                                     input logic [CHAR_W-1:0] c, input logic l,
                                     input logic h = 1'b0);
        name_byte_t it;
        it.start_req   = s;
        it.name_length = len;
        it.ch          = c;
        it.last        = l;
        it.hold        = h;
        byte_queue.push_back(it);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input int bad_pct);
        if (int'($urandom_range(99)) < bad_pct)
            return CHAR_W'($urandom_range(255));
        case ($urandom_range(5))
            0: return CHAR_W'($urandom_range(8'h41, 8'h5A));
            1: return CHAR_W'($urandom_range(8'h30, 8'h39));
            2: return CHAR_W'($urandom_range(8'h7B, 8'h7F));
            3:
            begin
                case ($urandom_range(2))
                    0: return 8'h5F;
                    1: return 8'h40;
                    default: return 8'h3F;
                endcase
            end
            default: return CHAR_W'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void add_name(input int n, input bit closed, input bit h);
        logic [LEN_W-1:0] len;
        if (int'($urandom_range(9)) == 0)
            len = LEN_W'($urandom_range(63));
        else
            len = (n > 63) ? 6'd63 : LEN_W'(n);
        for (int k = 0; k < n; k++)
            add_byte(k == 0, len, pick_char(8), closed && k == n - 1, h && k == 0);
    endfunction

    function automatic int send_idle_pct();
        case (sent_bytes * 5 / total_bytes)
            1: return 55;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (sent_bytes * 5 / total_bytes)
            2: return 55;
            3: return 35;
            default: return 0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_hash(cur_byte);
                sent_bytes++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (byte_queue.size() != 0 &&
                    !(byte_queue[0].hold && hash_queue.size() != 0) &&
                    int'($urandom_range(99)) >= send_idle_pct())
                begin
                    cur_byte = byte_queue.pop_front();
                    byte_ch.valid       <= 1'b1;
                    byte_ch.start_req   <= cur_byte.start_req;
                    byte_ch.name_length <= cur_byte.name_length;
                    byte_ch.ch          <= cur_byte.ch;
                    byte_ch.last        <= cur_byte.last;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        name_hash_t want;
        if (!rst_n)
        begin
            hash_ch.ready <= 1'b0;
        end
        else
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                if (hash_queue.size() == 0)
                begin
                    $error("unexpected result: hash_value=%h bad_name=%b",
                           hash_ch.hash_value, hash_ch.bad_name);
                    errors++;
                end
                else
                begin
                    want = hash_queue.pop_front();
                    if (hash_ch.hash_value !== want.hash)
                    begin
                        $error("hash_value: expected %h, got %h", want.hash,
                               hash_ch.hash_value);
                        errors++;
                    end
                    if (hash_ch.bad_name !== want.bad)
                    begin
                        $error("bad_name: expected %b, got %b", want.bad,
                               hash_ch.bad_name);
                        errors++;
                    end
                end
            end
            hash_ch.ready <= int'($urandom_range(99)) >= recv_stall_pct();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (hash_ch.valid && hash_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int r;
        int n;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.start_req   = 1'b0;
        byte_ch.name_length = '0;
        byte_ch.ch          = '0;
        byte_ch.last        = 1'b0;
        hash_ch.ready       = 1'b0;
        hash_acc            = '0;
        byte_pos            = '0;
        name_bad            = 1'b0;
        errors              = 0;
        sent_bytes          = 0;
        idle_cycles         = 0;

        // bytes with no start continue from the cleared state
        add_byte(1'b0, 6'd0, 8'h61, 1'b0);
        add_byte(1'b0, 6'd5, 8'h42, 1'b1);
        // empty names
        add_byte(1'b1, 6'd0, 8'hFF, 1'b1);
        add_byte(1'b1, 6'd0, 8'h00, 1'b0);
        add_byte(1'b0, 6'd0, 8'h39, 1'b1);
        // all legal classes, maximum declared length
        add_byte(1'b1, 6'd63, 8'h61, 1'b0);
        add_byte(1'b0, 6'd0, 8'h30, 1'b0);
        add_byte(1'b0, 6'd0, 8'h5F, 1'b0);
        add_byte(1'b0, 6'd0, 8'h40, 1'b0);
        add_byte(1'b0, 6'd0, 8'h3F, 1'b0);
        add_byte(1'b0, 6'd0, 8'h7F, 1'b0);
        add_byte(1'b0, 6'd0, 8'h5A, 1'b1);
        // illegal bytes, and an upper-case byte that folds to a legal one
        add_byte(1'b1, 6'd3, 8'h00, 1'b0);
        add_byte(1'b0, 6'd0, 8'hFF, 1'b0);
        add_byte(1'b0, 6'd0, 8'h20, 1'b1);
        add_byte(1'b1, 6'd1, 8'h41, 1'b1);
        add_byte(1'b1, 6'd42, 8'h60, 1'b0);
        add_byte(1'b0, 6'd21, 8'h3A, 1'b0);
        add_byte(1'b0, 6'd0, 8'h2F, 1'b0);
        add_byte(1'b0, 6'd0, 8'h5B, 1'b0);
        add_byte(1'b0, 6'd0, 8'h80, 1'b1);
        // restart in the middle of a name
        add_byte(1'b1, 6'd2, 8'h78, 1'b0);
        add_byte(1'b1, 6'd1, 8'h79, 1'b1, 1'b1);

        while (byte_queue.size() < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                n = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                add_name(n, 1'b1, byte_queue.size() > 400 && byte_queue.size() < 410);
            end
            else if (r < 88)
            begin
                add_byte(1'b1, 6'd0, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (r < 95)
            begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    add_byte(1'b0, LEN_W'($urandom_range(63)), CHAR_W'($urandom_range(255)),
                             k == n - 1 && $urandom_range(1) == 1);
            end
            else
            begin
                add_name($urandom_range(1, 6), 1'b0, 1'b0);
            end
        end
        total_bytes = byte_queue.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || byte_ch.valid || sent_bytes < total_bytes)
            @(posedge clk);
        while (hash_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ihash_pkg.sv
rtl/ihash_if.sv
rtl/ihash_ctrl.sv
rtl/ihash_dp.sv
rtl/identifier_name_hash_top.sv
bench/identifier_name_hash_top_test.sv
